>>> design/bmea_pkg.sv
// Shared widths and constants for the blocking mean and error accumulator.
// Used by the divider, the square-root unit and the top level; no dependencies.
package bmea_pkg;

  // Field and accumulator widths.
  localparam int VAL_W  = 24;  // block mean and running mean, Q8.16
  localparam int ERR_W  = 23;  // running error, unsigned Q7.16
  localparam int CNT_W  = 11;  // block count
  localparam int SUM_W  = 34;  // running sum of block means
  localparam int SQ_W   = 48;  // one squared block mean
  localparam int SSQ_W  = 57;  // running sum of squares
  localparam int VAR_W  = 47;  // mean of squares and variance, Q15.32

  // Shared serial divider: dividend, remainder and step counter widths.
  localparam int DIV_W  = 57;
  localparam int REM_W  = 11;
  localparam int LEN_W  = 6;

  // Serial square root: radicand and root widths.
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;

  // Largest reportable error.
  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

endpackage

>>> design/bmea_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on bmea_pkg; the caller aligns the dividend to the top of the word.
module bmea_div
  import bmea_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [LEN_W-1:0] len,
  input  logic [DIV_W-1:0] dividend,
  input  logic [REM_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic             busy_r;
  logic             done_r;
  logic [LEN_W-1:0] cnt_r;
  logic [DIV_W-1:0] q_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] d_r;

  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;
  logic [REM_W-1:0] rem_nxt;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial   = {rem_r, q_r[DIV_W-1]};
    diff    = trial - {1'b0, d_r};
    ge      = (trial >= {1'b0, d_r});
    rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
  end

  // Control: step counter and the done pulse after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LEN_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - LEN_W'(1);
        if (cnt_r == LEN_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: the dividend shifts out at the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  // A new division must not be launched while one is running.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

>>> design/bmea_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on bmea_pkg; takes a RAD_W-bit radicand, gives a ROOT_W-bit root.
module bmea_sqrt
  import bmea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int STEP_W = $clog2(ROOT_W + 1);
  localparam int RR_W   = ROOT_W + 2;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [RR_W-1:0]   rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [RR_W-1:0]   rem_sh;
  logic [RR_W-1:0]   trial;
  logic              ge;

  // One step: append two radicand bits and test the root with a one appended.
  always_comb begin
    rem_sh = {rem_r[RR_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // Control: fixed number of steps, then a done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == STEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: radicand shift register, partial remainder and growing root.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

  // A new root must not be launched while one is running.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("square root restarted while busy");

endmodule

>>> design/blocking_mean_error_accumulator.sv
// Top level of the blocking mean and standard error accumulator.
// Depends on bmea_pkg, bmea_div and bmea_sqrt.
//
//   Channel  Direction  Ports
//   in       input      in_valid, in_stall, in_block_mean, in_first_block
//   out      output     out_valid, out_stall, out_running_mean, out_running_error,
//                       out_blocks_seen, out_dropped
//
// One item is handled at a time. An item of a one-block run needs a 34-step division
// through the shared divider; any other adds a 57-step division and, if the variance
// is positive, a 47-step division and a 24-step square root. rst_n is synchronous
// and clears the sums, the count and the control. A finished result waits in the
// output register while out_stall is high, and the next transfer is taken meanwhile.
module blocking_mean_error_accumulator
  import bmea_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_block_mean,
  input  logic                    in_first_block,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_running_mean,
  output logic        [ERR_W-1:0] out_running_error,
  output logic        [CNT_W-1:0] out_blocks_seen,
  output logic                    out_dropped
);

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BLOCKS);
  localparam logic [LEN_W-1:0] LEN_MEAN = LEN_W'(SUM_W);
  localparam logic [LEN_W-1:0] LEN_MSQ  = LEN_W'(SSQ_W);
  localparam logic [LEN_W-1:0] LEN_VAR  = LEN_W'(VAR_W);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQR   = 10'b0000000010,
    S_ACC   = 10'b0000000100,
    S_DMEAN = 10'b0000001000,
    S_MSQ   = 10'b0000010000,
    S_DSQ   = 10'b0000100000,
    S_VAR   = 10'b0001000000,
    S_DVAR  = 10'b0010000000,
    S_ROOT  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t             state_r;
  logic               launch_r;
  logic               launch_nxt;
  logic [VAL_W-1:0]   v_r;
  logic               first_r;
  logic [SUM_W-1:0]   vs_r;
  logic [SSQ_W-1:0]   ss_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SQ_W-1:0]    sq_r;
  logic               drop_r;
  logic [VAL_W-1:0]   mean_r;
  logic [SQ_W-1:0]    mm_r;
  logic [VAR_W-1:0]   m2_r;
  logic [VAR_W-1:0]   var_r;
  logic [ERR_W-1:0]   err_r;
  logic               out_valid_r;
  logic [VAL_W-1:0]   out_mean_r;
  logic [ERR_W-1:0]   out_err_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_drop_r;

  logic               in_xfer;
  logic               out_free;
  logic [VAL_W-1:0]   v_mag;
  logic [VAL_W-1:0]   mean_mag;
  logic [SUM_W-1:0]   vs_mag;
  logic [CNT_W-1:0]   cnt_base;
  logic [SUM_W-1:0]   vs_base;
  logic [SSQ_W-1:0]   ss_base;
  logic [VAR_W:0]     var_diff;
  logic [VAL_W-1:0]   q_low;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [REM_W-1:0]   div_divisor;
  logic [LEN_W-1:0]   div_len;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  sqrt_root;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Magnitudes and the bases of the accumulation after an optional restart.
  always_comb begin
    v_mag    = v_r[VAL_W-1] ? (~v_r + VAL_W'(1)) : v_r;
    mean_mag = mean_r[VAL_W-1] ? (~mean_r + VAL_W'(1)) : mean_r;
    vs_mag   = vs_r[SUM_W-1] ? (~vs_r + SUM_W'(1)) : vs_r;
    cnt_base = first_r ? '0 : cnt_r;
    vs_base  = first_r ? '0 : vs_r;
    ss_base  = first_r ? '0 : ss_r;
    var_diff = {1'b0, m2_r} - {1'b0, mm_r[VAR_W-1:0]};
    q_low    = div_q[VAL_W-1:0];
  end

  // Divider operand selection; each dividend sits at the top of the divider word.
  always_comb begin
    case (state_r)
      S_DMEAN: begin
        div_dividend = {vs_mag, {(DIV_W-SUM_W){1'b0}}};
        div_divisor  = cnt_r[REM_W-1:0];
        div_len      = LEN_MEAN;
      end
      S_DSQ: begin
        div_dividend = ss_r;
        div_divisor  = cnt_r[REM_W-1:0];
        div_len      = LEN_MSQ;
      end
      S_DVAR: begin
        div_dividend = {var_r, {(DIV_W-VAR_W){1'b0}}};
        div_divisor  = cnt_r[REM_W-1:0] - REM_W'(1);
        div_len      = LEN_VAR;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
        div_len      = '0;
      end
    endcase
  end

  assign div_start  = launch_r && (state_r != S_ROOT);
  assign sqrt_start = launch_r && (state_r == S_ROOT);

  bmea_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .len      (div_len),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  bmea_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({1'b0, var_r}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Launch pulse for the divider or the square root on entry to each step.
  always_comb begin
    case (state_r)
      S_ACC:   launch_nxt = 1'b1;
      S_MSQ:   launch_nxt = 1'b1;
      S_VAR:   launch_nxt = !var_diff[VAR_W] && (var_diff != '0);
      S_DVAR:  launch_nxt = div_done;
      default: launch_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= 1'b0;
    end else begin
      launch_r <= launch_nxt;
    end
  end

  // Sequencer: square and accumulate, then mean and, for longer runs, mean of squares, variance and root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vs_r     <= '0;
      ss_r     <= '0;
      cnt_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_SQR;
          end
        end
        S_SQR: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (cnt_base < MAX_CNT) begin
            vs_r  <= vs_base + {{(SUM_W-VAL_W){v_r[VAL_W-1]}}, v_r};
            ss_r  <= ss_base + {{(SSQ_W-SQ_W){1'b0}}, sq_r};
            cnt_r <= cnt_base + CNT_W'(1);
          end
          state_r <= S_DMEAN;
        end
        S_DMEAN: begin
          if (div_done) begin
            if (cnt_r == CNT_W'(1)) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_MSQ;
            end
          end
        end
        S_MSQ: begin
          state_r <= S_DSQ;
        end
        S_DSQ: begin
          if (div_done) begin
            state_r <= S_VAR;
          end
        end
        S_VAR: begin
          if (var_diff[VAR_W] || (var_diff == '0)) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_DVAR;
          end
        end
        S_DVAR: begin
          if (div_done) begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Working datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      v_r     <= in_block_mean;
      first_r <= in_first_block;
    end
    if (state_r == S_SQR) begin
      sq_r <= SQ_W'(v_mag) * SQ_W'(v_mag);
    end
    if (state_r == S_ACC) begin
      drop_r <= (cnt_base >= MAX_CNT);
      err_r  <= '0;
    end
    if ((state_r == S_DMEAN) && div_done) begin
      mean_r <= vs_r[SUM_W-1] ? (~q_low + VAL_W'(1)) : q_low;
    end
    if (state_r == S_MSQ) begin
      mm_r <= SQ_W'(mean_mag) * SQ_W'(mean_mag);
    end
    if ((state_r == S_DSQ) && div_done) begin
      m2_r <= div_q[VAR_W-1:0];
    end
    if (state_r == S_VAR) begin
      var_r <= var_diff[VAR_W-1:0];
    end
    if ((state_r == S_DVAR) && div_done) begin
      var_r <= div_q[VAR_W-1:0];
    end
    if ((state_r == S_ROOT) && sqrt_done) begin
      err_r <= sqrt_root[ROOT_W-1] ? ERR_MAX : sqrt_root[ERR_W-1:0];
    end
  end

  // Output register: loaded from the finished item when the last transfer has gone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      out_mean_r <= mean_r;
      out_err_r  <= err_r;
      out_cnt_r  <= cnt_r;
      out_drop_r <= drop_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_running_mean  = out_mean_r;
  assign out_running_error = out_err_r;
  assign out_blocks_seen   = out_cnt_r;
  assign out_dropped       = out_drop_r;

  // A dropped item only happens on a full run.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_drop_r |-> out_cnt_r == MAX_CNT)
    else $error("dropped item reported on a run that is not full");

  // A single-block run carries no error.
  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cnt_r == CNT_W'(1)) |-> out_err_r == '0)
    else $error("nonzero error reported for a single block");

  // Every reported run holds at least one block, within the limit.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r != '0) && (out_cnt_r <= MAX_CNT))
    else $error("reported block count out of range");

endmodule

>>> tb/sv/tb_blocking_mean_error_accumulator.sv
// Self-checking testbench for the blocking mean and standard error accumulator.
// Needs bmea_pkg and blocking_mean_error_accumulator. It drives block means, predicts
// the running mean, error, count and drop flag, and checks every result transfer.
module tb_blocking_mean_error_accumulator
  import bmea_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_CAPACITY = 1024;
  localparam int HOLD_CYCLES  = 3000;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int PRINT_LIMIT  = 40;
  localparam int ITEM_TARGET  = 1500;

  localparam logic signed [VAL_W-1:0] MEAN_TOP = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] MEAN_BOTTOM = {1'b1, {(VAL_W-1){1'b0}}};

  typedef longint unsigned u64_t;

  // One block mean waiting to be offered.
  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    first;
  } block_item_t;

  // One predicted result.
  typedef struct {
    logic signed [VAL_W-1:0] running_mean;
    logic        [ERR_W-1:0] running_error;
    logic        [CNT_W-1:0] blocks_seen;
    logic                    dropped;
  } run_stats_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_block_mean = '0;
  logic                    in_first_block = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_running_mean;
  logic        [ERR_W-1:0] out_running_error;
  logic        [CNT_W-1:0] out_blocks_seen;
  logic                    out_dropped;

  block_item_t pending_blocks[$];
  run_stats_t  awaited_stats[$];

  // Predictor state: the current run of blocks.
  longint      run_sum = 0;
  u64_t        run_square_sum = 0;
  int unsigned run_count = 0;

  int  mismatches = 0;
  int  blocks_queued = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  hold_go = 1'b0;
  bit  in_taken = 1'b0;

  blocking_mean_error_accumulator #(.MAX_BLOCKS(RUN_CAPACITY)) dut (.*);

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bitwise integer square root, floor of the exact root.
  function automatic u64_t floor_root(u64_t x);
    u64_t root;
    u64_t trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (u64_t'(1) << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Adds one block to the predicted run and works out the reported statistics.
  function automatic run_stats_t accumulate_block(logic signed [VAL_W-1:0] mean_in,
                                                  logic first);
    longint     v;
    longint     n;
    longint     m;
    longint     m2;
    longint     spread;
    u64_t       root;
    run_stats_t r;
    v = mean_in;
    m = 0;
    root = 0;
    r.dropped = 1'b0;
    if (first) begin
      run_sum = 0;
      run_square_sum = 0;
      run_count = 0;
    end
    // A full run ignores the block and reports the unchanged state.
    if (run_count >= RUN_CAPACITY) begin
      r.dropped = 1'b1;
    end else begin
      run_sum += v;
      run_square_sum += u64_t'(v * v);
      run_count++;
    end
    if (run_count > 0) begin
      n = run_count;
      m = run_sum / n;
      // The error needs at least two blocks, and a negative variance counts as none.
      if (run_count > 1) begin
        m2 = longint'(run_square_sum / u64_t'(n));
        spread = m2 - m * m;
        if (spread > 0) begin
          root = floor_root(u64_t'(spread) / u64_t'(n - 1));
          if (root > ERR_MAX) root = ERR_MAX;
        end
      end
    end
    r.running_mean = m[VAL_W-1:0];
    r.running_error = root[ERR_W-1:0];
    r.blocks_seen = run_count[CNT_W-1:0];
    return r;
  endfunction

  // Idle length: mostly short, now and then long, none in calm phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 40);
    return $urandom_range(100, 300);
  endfunction

  // A block mean near the run's centre, or anywhere, or at an extreme, or near zero.
  function automatic logic signed [VAL_W-1:0] draw_mean(int centre);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 5) v = centre + int'($urandom_range(0, 8192)) - 4096;
    else if (r < 7) v = int'($urandom_range(0, 2**VAL_W - 1)) - 2**(VAL_W-1);
    else if (r < 8) v = $urandom_range(0, 1) ? int'(MEAN_TOP) : int'(MEAN_BOTTOM);
    else v = int'($urandom_range(0, 2**21)) - 2**20;
    if (v > int'(MEAN_TOP)) v = MEAN_TOP;
    if (v < int'(MEAN_BOTTOM)) v = MEAN_BOTTOM;
    return v[VAL_W-1:0];
  endfunction

  task automatic queue_block(logic signed [VAL_W-1:0] value, logic first);
    block_item_t b;
    b.value = value;
    b.first = first;
    pending_blocks.push_back(b);
    blocks_queued++;
  endtask

  // A run of blocks around one centre; a broken run omits the restart flag.
  task automatic queue_run(int len, bit restart);
    int centre;
    centre = int'($urandom_range(0, 2**VAL_W - 1)) - 2**(VAL_W-1);
    for (int i = 0; i < len; i++) begin
      queue_block(draw_mean(centre), (i == 0) && restart);
    end
  endtask

  // Blocks until every queued block is taken and every result has arrived.
  task automatic wait_for_drain();
    while (pending_blocks.size() != 0 || in_valid || awaited_stats.size() != 0)
      @(posedge clk);
  endtask

  task automatic flag_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Sender: holds a stalled transfer, otherwise idles or offers the next block.
  always @(negedge clk) begin : sender
    block_item_t b;
    int          gap_left;
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_blocks.size() != 0) begin
        b = pending_blocks.pop_front();
        in_block_mean <= b.value;
        in_first_block <= b.first;
        in_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  always @(negedge clk) begin : receiver
    int hold_left;
    int stall_left;
    bit hold_started;
    if (hold_go && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = ($urandom_range(0, 15) == 0) ? pick_gap() : 0;
    end
  end

  // Checks each result transfer, then predicts for each accepted block.
  always @(posedge clk) begin : scoreboard
    run_stats_t want;
    in_taken = 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_stats.size() == 0) begin
        flag_mismatch("result transfer with no block outstanding");
      end else begin
        want = awaited_stats.pop_front();
        if (out_running_mean !== want.running_mean)
          flag_mismatch($sformatf("running_mean got %0d want %0d",
                                  out_running_mean, want.running_mean));
        if (out_running_error !== want.running_error)
          flag_mismatch($sformatf("running_error got %0d want %0d",
                                  out_running_error, want.running_error));
        if (out_blocks_seen !== want.blocks_seen)
          flag_mismatch($sformatf("blocks_seen got %0d want %0d",
                                  out_blocks_seen, want.blocks_seen));
        if (out_dropped !== want.dropped)
          flag_mismatch($sformatf("dropped got %0b want %0b", out_dropped, want.dropped));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      awaited_stats.push_back(accumulate_block(in_block_mean, in_first_block));
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed blocks: a run opened without the flag, extremes, single-block runs,
    // identical blocks, the widest spread, truncation of a negative mean.
    queue_block('0, 1'b0);
    queue_block(MEAN_TOP, 1'b0);
    queue_block(MEAN_BOTTOM, 1'b0);
    queue_block(MEAN_BOTTOM, 1'b1);
    queue_block(MEAN_BOTTOM, 1'b0);
    queue_block(MEAN_TOP, 1'b0);
    queue_block(MEAN_TOP, 1'b1);
    queue_block(MEAN_BOTTOM, 1'b0);
    queue_block(-24'sd1, 1'b1);
    queue_block('0, 1'b0);
    queue_block(24'sd65536, 1'b1);
    queue_block(24'sd131072, 1'b0);
    queue_block(24'sd196608, 1'b0);
    queue_block(-24'sd65536, 1'b0);
    queue_block(24'sd1, 1'b1);
    queue_block(24'sd1, 1'b1);
    queue_block(-24'sd3, 1'b1);
    queue_block(24'sd2, 1'b0);
    queue_block(24'sd5, 1'b0);
    queue_block(-24'sd7, 1'b0);
    wait_for_drain();

    // Long receiver hold-off while the sender keeps offering, so the input stalls.
    hold_go = 1'b1;
    queue_run(8, 1'b1);
    wait_for_drain();

    // A stretch with no idling on either side.
    calm = 1'b1;
    repeat (6) queue_run($urandom_range(2, 12), 1'b1);
    wait_for_drain();
    calm = 1'b0;

    // Fill one run to capacity; the surplus blocks are dropped, then a restart.
    queue_run(RUN_CAPACITY + 6, 1'b1);
    queue_block(draw_mean(0), 1'b1);
    queue_run(3, 1'b0);
    wait_for_drain();

    // Random runs, mostly well formed, some without the restart flag.
    while (blocks_queued < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) queue_run(1, 1'b1);
      else queue_run($urandom_range(2, 30), $urandom_range(0, 9) != 0);
    end
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_stats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
design/bmea_pkg.sv
design/bmea_div.sv
design/bmea_sqrt.sv
design/blocking_mean_error_accumulator.sv
tb/sv/tb_blocking_mean_error_accumulator.sv
